/* rtl/core/msbs_pkg.sv */
// shared constants for the multi-signature byte scanner: window size, class codes
// and the fixed byte strings compared against the window; no dependencies
`default_nettype none

package msbs_pkg;

   localparam int WIN_LEN  = 19;
   localparam int CELL_CNT = WIN_LEN - 1;
   localparam int SIG_CNT  = 10;
   localparam int SIG_LEN  = 18;
   localparam int DIST_W   = 6;

   localparam logic [DIST_W-1:0] DIST_MAX  = 6'd63;
   localparam logic [DIST_W-1:0] MID_DIST  = 6'd17;
   localparam logic [DIST_W-1:0] BY_DIST   = 6'd41;
   localparam logic [DIST_W-1:0] TAIL_DIST = 6'd61;

   localparam logic [2:0] CLASS_NONE  = 3'd0;
   localparam logic [2:0] CLASS_LIST  = 3'd1;
   localparam logic [2:0] CLASS_THREE = 3'd2;
   localparam logic [2:0] CLASS_TWO   = 3'd3;
   localparam logic [2:0] CLASS_TAG   = 3'd4;

   // last character in the lowest byte, matching window byte 0 (newest)
   localparam logic [8*SIG_LEN-1:0] SIG_TEXT [SIG_CNT] = '{
      "SONG BY ST COMPILE",
      "SONG BY MB COMPILE",
      "SONG BY ST-COMPILE",
      {"SOUND ", "TRACKER v1.1"},
      "S.T.FULL EDITION  ",
      {8'h00, "S.T.FULL EDITION "},
      {"SOUND ", "TRACKER v1.3"},
      " STU SONG COMPILER",
      {"(C) K", "LAV \"S_", "SONIC\""},
      "ZX81 Compiler A.Re"
   };
   localparam logic [SIG_CNT-1:0] SIG_SHORT = 10'b00_0010_0000;

   localparam logic [8*8-1:0]  HDR_THREE = "PSC V1.0";
   localparam logic [8*16-1:0] MID_THREE = " COMPILATION OF ";
   localparam logic [8*4-1:0]  END_THREE = " BY ";
   localparam logic [8*8-1:0]  HDR_TWO   = "Module: ";
   localparam logic [8*19-1:0] END_TWO   = {";Fast ", "Tracker v1.00"};
   localparam logic [8*4-1:0]  TAG_SHORT = {"GTR", 8'h0a};

   typedef struct packed {
      logic step;
      logic last;
   } step_type;

endpackage

`default_nettype wire

/* rtl/core/msbs_cell.sv */
// one byte cell of the recent-byte window: loads its neighbor's byte on each
// transfer and clears at end of file; no package dependency
`default_nettype none

module msbs_cell (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic       clear,
   input  wire logic [7:0] byte_in,
   output logic      [7:0] byte_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_mux;

   always_comb begin
      byte_in_mux = byte_ff;
      if (step) begin
         byte_in_mux = clear ? 8'h00 : byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in_mux;
      end
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

/* rtl/core/msbs_match.sv */
// string compares on the shifted window, header tracking and class select
// depends on msbs_pkg for strings, distances and class codes
`default_nettype none

module msbs_match
   import msbs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire step_type             ctrl,
   input  wire logic [8*WIN_LEN-1:0] win,
   output logic      [2:0]           format_class
);

   logic              list_ff,  list_in;
   logic              th_seen_ff, th_seen_in;
   logic [DIST_W-1:0] th_dist_ff, th_dist_in;
   logic              th_mid_ff, th_mid_in;
   logic              th_ok_ff, th_ok_in;
   logic              tw_seen_ff, tw_seen_in;
   logic [DIST_W-1:0] tw_dist_ff, tw_dist_in;
   logic              tw_ok_ff, tw_ok_in;
   logic              tag_ff, tag_in;
   logic [SIG_CNT-1:0] sig_hit;

   always_comb begin
      for (int i = 0; i < SIG_CNT; i++) begin
         if (SIG_SHORT[i]) begin
            sig_hit[i] = win[8*(SIG_LEN-1)-1:0] == SIG_TEXT[i][8*(SIG_LEN-1)-1:0];
         end else begin
            sig_hit[i] = win[8*SIG_LEN-1:0] == SIG_TEXT[i];
         end
      end
   end

   always_comb begin
      list_in    = list_ff | (|sig_hit);
      th_seen_in = th_seen_ff;
      th_dist_in = th_dist_ff;
      th_mid_in  = th_mid_ff;
      th_ok_in   = th_ok_ff;
      tw_seen_in = tw_seen_ff;
      tw_dist_in = tw_dist_ff;
      tw_ok_in   = tw_ok_ff;
      tag_in     = tag_ff | (win[31:0] == TAG_SHORT);

      if (th_seen_ff) begin
         if (th_dist_ff < DIST_MAX) begin
            th_dist_in = th_dist_ff + 6'd1;
         end
         if (th_dist_in == MID_DIST && win[127:0] == MID_THREE) begin
            th_mid_in = 1'b1;
         end
         if (th_dist_in == BY_DIST && th_mid_ff && win[31:0] == END_THREE) begin
            th_ok_in = 1'b1;
         end
      end else if (win[63:0] == HDR_THREE) begin
         th_seen_in = 1'b1;
         th_dist_in = '0;
      end

      if (tw_seen_ff) begin
         if (tw_dist_ff < DIST_MAX) begin
            tw_dist_in = tw_dist_ff + 6'd1;
         end
         if (tw_dist_in == TAIL_DIST && win[151:0] == END_TWO) begin
            tw_ok_in = 1'b1;
         end
      end else if (win[63:0] == HDR_TWO) begin
         tw_seen_in = 1'b1;
         tw_dist_in = '0;
      end
   end

   always_comb begin
      if (list_in) begin
         format_class = CLASS_LIST;
      end else if (th_ok_in) begin
         format_class = CLASS_THREE;
      end else if (tw_ok_in) begin
         format_class = CLASS_TWO;
      end else if (tag_in) begin
         format_class = CLASS_TAG;
      end else begin
         format_class = CLASS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl.step && ctrl.last)) begin
         list_ff    <= 1'b0;
         th_seen_ff <= 1'b0;
         th_dist_ff <= '0;
         th_mid_ff  <= 1'b0;
         th_ok_ff   <= 1'b0;
         tw_seen_ff <= 1'b0;
         tw_dist_ff <= '0;
         tw_ok_ff   <= 1'b0;
         tag_ff     <= 1'b0;
      end else if (ctrl.step) begin
         list_ff    <= list_in;
         th_seen_ff <= th_seen_in;
         th_dist_ff <= th_dist_in;
         th_mid_ff  <= th_mid_in;
         th_ok_ff   <= th_ok_in;
         tw_seen_ff <= tw_seen_in;
         tw_dist_ff <= tw_dist_in;
         tw_ok_ff   <= tw_ok_in;
         tag_ff     <= tag_in;
      end
   end

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.step && ctrl.last |=> !list_ff && !th_seen_ff && !tw_seen_ff && !tag_ff)
      else $error("match state not cleared after end of file");

   a_ok_needs_header: assert property (@(posedge clock) disable iff (reset)
      th_ok_ff |-> th_seen_ff && th_mid_ff)
      else $error("three-part match without header and middle string");

   a_dist_idle: assert property (@(posedge clock) disable iff (reset)
      !tw_seen_ff |-> tw_dist_ff == '0 && !tw_ok_ff)
      else $error("two-part distance running without header");

endmodule

`default_nettype wire

/* rtl/core/multi_signature_byte_scanner.sv */
// top level of the multi-signature byte scanner: window cell chain, matcher and
// result register; depends on msbs_pkg, msbs_cell and msbs_match
//
//   channel   dir   payload                                  end of item
//   req_*     in    tdata[7:0] data_byte, tlast last_byte    tvalid & tready
//   rsp_*     out   tdata[2:0] format_class, [7:3] zero      tvalid & tready
//
// one byte per cycle while req_tready is high; every compare runs in parallel on the shifted window
// a result is valid in the cycle after the transfer of a byte with tlast set
// a held result stalls input only while rsp_tready is low
// synchronous reset clears the window, the match flags and the result valid
`default_nettype none

module multi_signature_byte_scanner
   import msbs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // last_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata    // [2:0] format_class, [7:3] zero
);

   logic [7:0]           cell_q [CELL_CNT];
   logic [8*WIN_LEN-1:0] win;
   step_type             ctrl;
   logic [2:0]           cls;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_class_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign ctrl.step  = req_tvalid && req_tready;
   assign ctrl.last  = req_tlast;

   for (genvar j = 0; j < CELL_CNT; j++) begin : g_cell
      msbs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (ctrl.step),
         .clear    (req_tlast),
         .byte_in  (j == 0 ? req_tdata : cell_q[(j == 0) ? 0 : j-1]),
         .byte_out (cell_q[j])
      );
      assign win[8*(j+1) +: 8] = cell_q[j];
   end
   assign win[7:0] = req_tdata;

   msbs_match u_match (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .win          (win),
      .format_class (cls)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (ctrl.step && ctrl.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step && ctrl.last) begin
         rsp_class_ff <= cls;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_class_ff};

   a_eof_gives_result: assert property (@(posedge clock) disable iff (reset)
      ctrl.step && ctrl.last |=> rsp_tvalid)
      else $error("end of file transfer without result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a pending result");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_class_ff <= CLASS_TAG)
      else $error("result class out of range");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// self-checking bench for multi_signature_byte_scanner: random files of bytes, most built
// around the headers, signatures and tags the block looks for, checked against a predictor
// depends on msbs_pkg for the class codes and on the scanner rtl
`default_nettype none

module testbench
   import msbs_pkg::*;
();

   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD   = 300;
   localparam int BYTE_GOAL   = 1050;
   localparam int FILE_GOAL   = 20;

   localparam logic [5:0] MIDDLE_AT = 6'd17;
   localparam logic [5:0] BY_AT     = 6'd41;
   localparam logic [5:0] TAIL_AT   = 6'd61;
   localparam logic [5:0] DIST_CAP  = 6'd63;

   localparam logic [8*8-1:0]  PSC_HEADER    = "PSC V1.0";
   localparam logic [8*16-1:0] COMP_MIDDLE   = " COMPILATION OF ";
   localparam logic [8*4-1:0]  BY_TAIL       = " BY ";
   localparam logic [8*8-1:0]  MODULE_HEADER = "Module: ";
   localparam logic [8*19-1:0] COMPILER_TAIL = {";Fast ", "Tracker v1.00"};
   localparam logic [8*4-1:0]  GTR_TAG       = {"GTR", 8'h0a};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [2:0] format_class, [7:3] zero

   multi_signature_byte_scanner uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // last character in the lowest byte
   function automatic logic [151:0] signature_text(input int idx);
      case (idx)
         0: return "SONG BY ST COMPILE";
         1: return "SONG BY MB COMPILE";
         2: return "SONG BY ST-COMPILE";
         3: return {"SOUND ", "TRACKER v1.1"};
         4: return "S.T.FULL EDITION  ";
         5: return "S.T.FULL EDITION ";
         6: return {"SOUND ", "TRACKER v1.3"};
         7: return " STU SONG COMPILER";
         8: return {"(C) K", "LAV \"S_", "SONIC\""};
         default: return "ZX81 Compiler A.Re";
      endcase
   endfunction

   function automatic int signature_len(input int idx);
      return (idx == 5) ? 17 : 18;
   endfunction

   class format_scoreboard;
      logic [151:0] window;
      bit           list_seen, tag_seen;
      bit           three_hdr, three_mid, three_ok;
      bit           two_hdr, two_ok;
      logic [5:0]   three_dist, two_dist;
      logic [2:0]   expected_class[$];
      int           mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         window = '0;
         list_seen = 0;
         tag_seen = 0;
         three_hdr = 0;
         three_mid = 0;
         three_ok = 0;
         two_hdr = 0;
         two_ok = 0;
         three_dist = '0;
         two_dist = '0;
      endfunction

      function bit tail_is(input logic [151:0] pat, input int len);
         logic [151:0] mask;
         mask = {152{1'b1}} >> (8 * (19 - len));
         return (window & mask) == (pat & mask);
      endfunction

      function void take_byte(input logic [7:0] b, input logic last);
         logic [2:0] cls;
         window = {window[143:0], b};
         for (int i = 0; i < 10; i++) begin
            if (tail_is(signature_text(i), signature_len(i))) list_seen = 1;
         end
         if (three_hdr) begin
            if (three_dist < DIST_CAP) three_dist++;
            if (three_dist == MIDDLE_AT && tail_is(COMP_MIDDLE, 16)) three_mid = 1;
            if (three_dist == BY_AT && three_mid && tail_is(BY_TAIL, 4)) three_ok = 1;
         end else if (tail_is(PSC_HEADER, 8)) begin
            three_hdr = 1;
            three_dist = '0;
         end
         if (two_hdr) begin
            if (two_dist < DIST_CAP) two_dist++;
            if (two_dist == TAIL_AT && tail_is(COMPILER_TAIL, 19)) two_ok = 1;
         end else if (tail_is(MODULE_HEADER, 8)) begin
            two_hdr = 1;
            two_dist = '0;
         end
         if (tail_is(GTR_TAG, 4)) tag_seen = 1;
         if (last) begin
            if (list_seen) cls = CLASS_LIST;
            else if (three_ok) cls = CLASS_THREE;
            else if (two_ok) cls = CLASS_TWO;
            else if (tag_seen) cls = CLASS_TAG;
            else cls = CLASS_NONE;
            expected_class.push_back(cls);
            clear();
         end
      endfunction

      function void match_class(input logic [7:0] tdata);
         logic [2:0] want;
         if (expected_class.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer, tdata %h", tdata);
         end else begin
            want = expected_class.pop_front();
            if (tdata !== {5'b0, want}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("class mismatch: expected %0d, got tdata %h", want, tdata);
            end
         end
      endfunction

      function int pending();
         return expected_class.size();
      endfunction
   endclass

   format_scoreboard board;
   logic [7:0]       file_q[$];
   int               sent_bytes = 0;
   bit               hold_request = 0;
   int               quiet = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // random bytes, half of them taken from the signature alphabet
   task automatic put_noise(input int n);
      logic [151:0] src;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 1)) begin
            file_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            src = signature_text($urandom_range(0, 9));
            file_q.push_back(src[8*$urandom_range(0, 16) +: 8]);
         end
      end
   endtask

   task automatic put_text(input logic [151:0] pat, input int len, input bit intact);
      int         spoil;
      logic [7:0] b;
      spoil = intact ? -1 : int'($urandom_range(0, len - 1));
      for (int k = len - 1; k >= 0; k--) begin
         b = pat[8*k +: 8];
         if (k == spoil) b = b ^ 8'($urandom_range(1, 255));
         file_q.push_back(b);
      end
   endtask

   function automatic int near_gap(input int n);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return n - 1;
      if (r == 1) return n + 1;
      return n;
   endfunction

   task automatic build_file();
      bit want_three, want_two, want_tag, want_sig;
      int idx, cut;
      file_q.delete();
      if ($urandom_range(0, 99) < 35) begin
         put_noise($urandom_range(1, 20));
      end else begin
         want_three = $urandom_range(0, 99) < 40;
         want_two   = $urandom_range(0, 99) < 35;
         want_tag   = $urandom_range(0, 99) < 30;
         want_sig   = $urandom_range(0, 99) < 25;
         if (!(want_three || want_two || want_tag || want_sig)) begin
            case ($urandom_range(0, 3))
               0: want_three = 1;
               1: want_two = 1;
               2: want_tag = 1;
               default: want_sig = 1;
            endcase
         end
         put_noise($urandom_range(0, 4));
         if (want_three) begin
            // an earlier header that is judged instead of the good one
            if ($urandom_range(0, 7) == 0) begin
               put_text(PSC_HEADER, 8, 1'b1);
               put_noise($urandom_range(0, 8));
            end
            put_text(PSC_HEADER, 8, $urandom_range(0, 9) != 0);
            put_noise(near_gap(1));
            put_text(COMP_MIDDLE, 16, $urandom_range(0, 4) != 0);
            put_noise(near_gap(20));
            put_text(BY_TAIL, 4, $urandom_range(0, 4) != 0);
         end
         if (want_two) begin
            if ($urandom_range(0, 7) == 0) begin
               put_text(MODULE_HEADER, 8, 1'b1);
               put_noise($urandom_range(0, 8));
            end
            put_text(MODULE_HEADER, 8, $urandom_range(0, 9) != 0);
            put_noise(near_gap(42));
            put_text(COMPILER_TAIL, 19, $urandom_range(0, 4) != 0);
         end
         if (want_tag) begin
            put_noise($urandom_range(0, 4));
            put_text(GTR_TAG, 4, $urandom_range(0, 6) != 0);
         end
         if (want_sig) begin
            idx = $urandom_range(0, 9);
            put_noise($urandom_range(0, 4));
            put_text(signature_text(idx), signature_len(idx), $urandom_range(0, 4) != 0);
         end
         put_noise($urandom_range(0, 4));
         // file may be cut short at a random byte, possibly before a required string is complete
         if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, file_q.size());
            while (file_q.size() > cut) file_q.delete(file_q.size() - 1);
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] d, input logic last, input bit calm);
      int n;
      n = calm ? 0 : pick_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_byte(d, last);
      sent_bytes++;
   endtask

   task automatic send_file(input bit calm);
      for (int k = 0; k < file_q.size(); k++)
         send_byte(file_q[k], k == file_q.size() - 1, calm);
   endtask

   // stop offering and wait for every expected result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.match_class(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: random stalls, one long hold on request
   initial begin
      int n, m;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         m = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
         repeat (m) @(posedge clock);
      end
   end

   initial begin
      int files;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // extreme bytes as one-byte files, the tag alone, the short signature alone
      file_q.delete();
      file_q.push_back(8'hff);
      send_file(1'b0);
      file_q.delete();
      file_q.push_back(8'h00);
      send_file(1'b1);
      file_q.delete();
      put_text(GTR_TAG, 4, 1'b1);
      send_file(1'b0);
      file_q.delete();
      put_text(signature_text(5), 17, 1'b1);
      send_file(1'b1);
      wait_drained();

      files = 0;
      while (sent_bytes < BYTE_GOAL || files < FILE_GOAL) begin
         if (files == 8 || files == 18) wait_drained();
         if (files == 15) hold_request = 1;
         build_file();
         send_file($urandom_range(0, 3) == 0);
         files++;
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
